/* rtl/core/gts_pkg.sv */
`timescale 1ns / 1ps
package gts_pkg;
   // Input columns that exist on the ports
   localparam int IN_COLS = 3;
   localparam int MAX_COLUMNS_DEF = 3;
   localparam int COUNT_BITS_DEF = 20;

   // Log unit: mantissa Q1.62, log2 result Q6.56
   localparam int FRAC_BITS = 56;
   localparam int MANT_BITS = 64;
   localparam int K_BITS = 6;
   localparam int LG_BITS = K_BITS + FRAC_BITS;
   localparam logic [63:0] LN2_Q64 = 64'hB17217F7D1CF79AB;

   // Lane depth: exponent, normalize, two stages per fraction bit, ln multiply, term multiply
   localparam int LANE_LAT = 2 * FRAC_BITS + 6;

   // Accumulator and output format
   localparam int ACC_BITS = 128;
   localparam int G_BITS = 38;
   localparam int G_SHIFT = 39;

   // Mantissa, fraction bits found so far and exponent of one log evaluation
   typedef struct packed {
      logic [MANT_BITS-1:0] mant;
      logic [FRAC_BITS-1:0] frac;
      logic [K_BITS-1:0]    k;
   } log_type;
endpackage

/* rtl/core/gts_square_step.sv */
`timescale 1ns / 1ps
module gts_square_step #(
   parameter int XW = 23
) (
   input  logic                clock,
   input  logic                adv,
   input  gts_pkg::log_type    log_in,
   input  logic [XW-1:0]       x_in,
   output gts_pkg::log_type    log_out,
   output logic [XW-1:0]       x_out
);
   logic [63:0] p11_ff, p10_ff, p00_ff;
   logic [gts_pkg::FRAC_BITS-1:0] frac_ff;
   logic [gts_pkg::K_BITS-1:0] k_ff;
   logic [XW-1:0] x_ff;
   logic [127:0] sq;
   logic [63:0] mn;
   gts_pkg::log_type log_ff;
   logic [XW-1:0] xo_ff;

   // Partial products of the mantissa square
   always_ff @(posedge clock) begin
      if (adv) begin
         p11_ff  <= 64'(log_in.mant[63:32]) * 64'(log_in.mant[63:32]);
         p10_ff  <= 64'(log_in.mant[63:32]) * 64'(log_in.mant[31:0]);
         p00_ff  <= 64'(log_in.mant[31:0]) * 64'(log_in.mant[31:0]);
         frac_ff <= log_in.frac;
         k_ff    <= log_in.k;
         x_ff    <= x_in;
      end
   end

   // Sum the square, keep Q.62
   assign sq = {p11_ff, 64'b0} + {31'b0, p10_ff, 33'b0} + {64'b0, p00_ff};
   assign mn = sq[125:62];

   // Emit one fraction bit, halve the mantissa when it reached two
   always_ff @(posedge clock) begin
      if (adv) begin
         log_ff.mant <= mn[63] ? {1'b0, mn[63:1]} : mn;
         log_ff.frac <= {frac_ff[gts_pkg::FRAC_BITS-2:0], mn[63]};
         log_ff.k    <= k_ff;
         xo_ff       <= x_ff;
      end
   end

   assign log_out = log_ff;
   assign x_out = xo_ff;
endmodule

/* rtl/core/gts_log_lane.sv */
`timescale 1ns / 1ps
module gts_log_lane #(
   parameter int XW = 23
) (
   input  logic             clock,
   input  logic             adv,
   input  logic [XW-1:0]    x_in,
   output logic [XW+63:0]   term_out
);
   localparam int NSTEP = gts_pkg::FRAC_BITS;
   localparam logic [gts_pkg::K_BITS-1:0] TOP_POS = gts_pkg::K_BITS'(gts_pkg::MANT_BITS - 2);

   logic [gts_pkg::K_BITS-1:0] k_in, k_ff;
   logic [XW-1:0] x0_ff, x1_ff;
   gts_pkg::log_type head_ff;
   gts_pkg::log_type chain [NSTEP+1];
   logic [XW-1:0] xc [NSTEP+1];
   logic [gts_pkg::LG_BITS-1:0] lg;
   logic [63:0] phh_ff, phl_ff, plh_ff, pll_ff;
   logic [XW-1:0] xm_ff, xn_ff;
   logic [127:0] lsum;
   logic [63:0] ln_ff;
   logic [XW+31:0] ph_ff, pl_ff;
   logic [XW+63:0] term_ff;

   // Find the leading one
   always_comb begin
      k_in = '0;
      for (int i = 0; i < XW; i++) begin
         if (x_in[i]) k_in = gts_pkg::K_BITS'(i);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         k_ff  <= k_in;
         x0_ff <= x_in;
      end
   end

   // Normalize into Q1.62
   always_ff @(posedge clock) begin
      if (adv) begin
         head_ff.mant <= gts_pkg::MANT_BITS'(x0_ff) << (TOP_POS - k_ff);
         head_ff.frac <= '0;
         head_ff.k    <= k_ff;
         x1_ff        <= x0_ff;
      end
   end

   assign chain[0] = head_ff;
   assign xc[0] = x1_ff;

   // One fraction bit per step
   for (genvar s = 0; s < NSTEP; s++) begin : g_step
      gts_square_step #(.XW(XW)) u_step (
         .clock   (clock),
         .adv     (adv),
         .log_in  (chain[s]),
         .x_in    (xc[s]),
         .log_out (chain[s+1]),
         .x_out   (xc[s+1])
      );
   end

   // log2 times ln2, partial products
   assign lg = {chain[NSTEP].k, chain[NSTEP].frac};

   always_ff @(posedge clock) begin
      if (adv) begin
         phh_ff <= 64'(lg[gts_pkg::LG_BITS-1:32]) * 64'(gts_pkg::LN2_Q64[63:32]);
         phl_ff <= 64'(lg[gts_pkg::LG_BITS-1:32]) * 64'(gts_pkg::LN2_Q64[31:0]);
         plh_ff <= 64'(lg[31:0]) * 64'(gts_pkg::LN2_Q64[63:32]);
         pll_ff <= 64'(lg[31:0]) * 64'(gts_pkg::LN2_Q64[31:0]);
         xm_ff  <= xc[NSTEP];
      end
   end

   assign lsum = {phh_ff, 64'b0} + {32'b0, phl_ff, 32'b0} + {32'b0, plh_ff, 32'b0}
               + {64'b0, pll_ff};

   // Keep the upper half as ln in Q6.56
   always_ff @(posedge clock) begin
      if (adv) begin
         ln_ff <= lsum[127:64];
         xn_ff <= xm_ff;
      end
   end

   // x times ln x, split on the ln word
   always_ff @(posedge clock) begin
      if (adv) begin
         ph_ff <= (XW+32)'(xn_ff) * (XW+32)'(ln_ff[63:32]);
         pl_ff <= (XW+32)'(xn_ff) * (XW+32)'(ln_ff[31:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) term_ff <= {ph_ff, 32'b0} + (XW+64)'(pl_ff);
   end

   assign term_out = term_ff;
endmodule

/* rtl/core/gts_merge.sv */
`timescale 1ns / 1ps
module gts_merge #(
   parameter int NL = 12,
   parameter int TW = 87,
   parameter logic [NL-1:0] NEG = '0
) (
   input  logic                          clock,
   input  logic                          adv,
   input  logic [TW-1:0]                 term_in [NL],
   output logic [gts_pkg::G_BITS-1:0]    g_out
);
   localparam int AW = gts_pkg::ACC_BITS;
   localparam int LV = $clog2(NL);
   localparam int NP = 1 << LV;
   localparam int HI = gts_pkg::G_SHIFT + gts_pkg::G_BITS;

   logic [AW-1:0] lvl_ff [LV+1][NP];
   logic [AW-1:0] acc;
   logic [gts_pkg::G_BITS-1:0] g_ff;

   // Apply each lane's sign, pad the tree with zeros
   for (genvar i = 0; i < NP; i++) begin : g_leaf
      if (i < NL) begin : g_used
         always_ff @(posedge clock) begin
            if (adv) lvl_ff[0][i] <= NEG[i] ? (AW'(0) - AW'(term_in[i])) : AW'(term_in[i]);
         end
      end else begin : g_pad
         always_ff @(posedge clock) begin
            if (adv) lvl_ff[0][i] <= '0;
         end
      end
   end

   // Registered adder tree
   for (genvar j = 0; j < LV; j++) begin : g_level
      for (genvar i = 0; i < (NP >> (j + 1)); i++) begin : g_node
         always_ff @(posedge clock) begin
            if (adv) lvl_ff[j+1][i] <= lvl_ff[j][2*i] + lvl_ff[j][2*i+1];
         end
      end
   end

   assign acc = lvl_ff[LV][0];

   // Clamp negative, saturate large, scale to Q.16
   always_ff @(posedge clock) begin
      if (adv) begin
         if (acc[AW-1])
            g_ff <= '0;
         else if (|acc[AW-1:HI])
            g_ff <= '1;
         else
            g_ff <= acc[HI-1:gts_pkg::G_SHIFT];
      end
   end

   assign g_out = g_ff;
endmodule

/* rtl/core/g_test_statistic_2x3_unit.sv */
`timescale 1ns / 1ps
// G likelihood-ratio statistic of a 2 x up-to-3 table of counts.
// Request channel (req_valid / req_ready) carries one table per transaction:
// row 0 counts req_unaffected_a..c, row 1 counts req_affected_a..c.
// Response channel (rsp_valid / rsp_ready) returns one transaction per table:
// rsp_g_statistic in unsigned Q22.16, saturating, and rsp_degenerate, set
// (with a zero statistic) when a row total is zero.
// Throughput: one table per cycle while req_ready is high. Every table
// count, column total, row total and grand total has its own log lane;
// each lane resolves one fraction bit of log2 per square step (two stages
// a step, 56 steps), then multiplies by ln2 and by the count. A registered
// adder tree merges the lanes. When the receiver stalls, the output
// register and one skid entry hold results; once the skid entry fills,
// req_ready drops and the whole pipeline holds. Reset clears all valid
// state; in-flight tables are dropped.
module g_test_statistic_2x3_unit #(
   parameter int MAX_COLUMNS = gts_pkg::MAX_COLUMNS_DEF,
   parameter int COUNT_BITS  = gts_pkg::COUNT_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [COUNT_BITS-1:0]       req_unaffected_a,
   input  logic [COUNT_BITS-1:0]       req_unaffected_b,
   input  logic [COUNT_BITS-1:0]       req_unaffected_c,
   input  logic [COUNT_BITS-1:0]       req_affected_a,
   input  logic [COUNT_BITS-1:0]       req_affected_b,
   input  logic [COUNT_BITS-1:0]       req_affected_c,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [gts_pkg::G_BITS-1:0]  rsp_g_statistic,
   output logic                        rsp_degenerate
);
   localparam int NC  = (MAX_COLUMNS < gts_pkg::IN_COLS) ? MAX_COLUMNS : gts_pkg::IN_COLS;
   localparam int XW  = COUNT_BITS + 3;
   localparam int TW  = XW + 64;
   localparam int NL  = 3 * NC + 3;
   localparam int ML  = $clog2(NL) + 2;
   localparam int DLY = 1 + gts_pkg::LANE_LAT + ML;
   // Column totals and both row totals subtract
   localparam logic [NL-1:0] NEG_MASK = NL'(((1 << (NC + 2)) - 1) << (2 * NC));

   logic [COUNT_BITS-1:0] row0 [gts_pkg::IN_COLS];
   logic [COUNT_BITS-1:0] row1 [gts_pkg::IN_COLS];
   logic [XW-1:0] x_in [NL];
   logic [XW-1:0] x_ff [NL];
   logic [XW-1:0] s0, s1;
   logic deg_in;
   logic adv, pop;
   logic [DLY-1:0] v_ff, d_ff;
   logic [TW-1:0] term [NL];
   logic [gts_pkg::G_BITS-1:0] merge_g, tail_g;
   logic rsp_valid_ff, rsp_d_ff, skid_v_ff, skid_d_ff;
   logic [gts_pkg::G_BITS-1:0] rsp_g_ff, skid_g_ff;

   assign row0[0] = req_unaffected_a;
   assign row0[1] = req_unaffected_b;
   assign row0[2] = req_unaffected_c;
   assign row1[0] = req_affected_a;
   assign row1[1] = req_affected_b;
   assign row1[2] = req_affected_c;

   // Cells, column totals, row totals, grand total
   always_comb begin
      s0 = '0;
      s1 = '0;
      for (int c = 0; c < NC; c++) begin
         x_in[c]        = XW'(row0[c]);
         x_in[NC + c]   = XW'(row1[c]);
         x_in[2*NC + c] = XW'(row0[c]) + XW'(row1[c]);
         s0 = s0 + XW'(row0[c]);
         s1 = s1 + XW'(row1[c]);
      end
      x_in[3*NC]     = s0;
      x_in[3*NC + 1] = s1;
      x_in[3*NC + 2] = s0 + s1;
   end

   assign deg_in = (s0 == '0) || (s1 == '0);

   // Pipeline advances while the skid entry is free
   assign adv = !skid_v_ff;
   assign req_ready = adv;

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int l = 0; l < NL; l++) x_ff[l] <= x_in[l];
      end
   end

   // Track transaction valid and degenerate flag alongside the lanes
   always_ff @(posedge clock) begin
      if (reset)
         v_ff <= '0;
      else if (adv)
         v_ff <= {v_ff[DLY-2:0], req_valid};
   end

   always_ff @(posedge clock) begin
      if (adv) d_ff <= {d_ff[DLY-2:0], deg_in};
   end

   for (genvar l = 0; l < NL; l++) begin : g_lane
      gts_log_lane #(.XW(XW)) u_lane (
         .clock    (clock),
         .adv      (adv),
         .x_in     (x_ff[l]),
         .term_out (term[l])
      );
   end

   gts_merge #(.NL(NL), .TW(TW), .NEG(NEG_MASK)) u_merge (
      .clock   (clock),
      .adv     (adv),
      .term_in (term),
      .g_out   (merge_g)
   );

   assign pop = adv && v_ff[DLY-1];
   assign tail_g = d_ff[DLY-1] ? '0 : merge_g;

   // Output register with one skid entry
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         skid_v_ff    <= 1'b0;
      end else if (skid_v_ff) begin
         if (rsp_ready) skid_v_ff <= 1'b0;
      end else if (pop) begin
         if (!rsp_valid_ff || rsp_ready)
            rsp_valid_ff <= 1'b1;
         else
            skid_v_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_v_ff) begin
         if (rsp_ready) begin
            rsp_g_ff <= skid_g_ff;
            rsp_d_ff <= skid_d_ff;
         end
      end else if (pop) begin
         if (!rsp_valid_ff || rsp_ready) begin
            rsp_g_ff <= tail_g;
            rsp_d_ff <= d_ff[DLY-1];
         end else begin
            skid_g_ff <= tail_g;
            skid_d_ff <= d_ff[DLY-1];
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_g_statistic = rsp_g_ff;
   assign rsp_degenerate = rsp_d_ff;

   // Skid entry only fills behind a held output
   a_skid_behind_out: assert property (@(posedge clock) skid_v_ff |-> rsp_valid_ff)
      else $error("skid entry valid without output valid");

   // Degenerate tables report a zero statistic
   a_degenerate_zero: assert property (@(posedge clock)
      rsp_valid_ff && rsp_d_ff |-> rsp_g_ff == '0)
      else $error("degenerate result with nonzero statistic");

   // Reset empties pipeline and output
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid_ff && !skid_v_ff && (v_ff == '0))
      else $error("valid state survived reset");

   // A result arriving at a stalled output lands in the skid entry
   a_stall_to_skid: assert property (@(posedge clock) disable iff (reset)
      pop && rsp_valid_ff && !rsp_ready |=> skid_v_ff)
      else $error("result lost at stalled output");
endmodule
